// ===== hdl/sre_pkg.sv =====
// Package for the slot region evidence block: register layout, codes,
// summary and divider handshake types. No dependencies.
package sre_pkg;

  localparam int GRID_WIDTH  = 256;
  localparam int GRID_HEIGHT = 256;

  localparam int CNT_W      = 17;
  localparam int PEAK_W     = 15;
  localparam int RATIO_W    = 17;
  localparam int SLOT_W     = 16;
  localparam int COORD_W    = 32;
  localparam int CSIZE_W    = 21;
  localparam int SCORE_W    = 17;
  localparam int HEIGHT_W   = 16;
  localparam int IDX_W      = 8;
  localparam int PROD_W     = IDX_W + 1 + CSIZE_W;
  localparam int CENTER_W   = COORD_W + 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [RATIO_W-1:0] ONE_Q16   = 17'd65536;

  // dividend is count << 16, one bit per step
  localparam int DIV_STEPS = CNT_W + 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIS_THR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_THR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_THR = 3'd5;

  typedef enum logic [1:0] {
    CAT_UNKNOWN  = 2'd0,
    CAT_OCCUPIED = 2'd1,
    CAT_FREE     = 2'd2
  } category_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV_OCC,
    B_DIV_VIS,
    B_FIN
  } back_state_t;

  typedef struct packed {
    logic [COORD_W-1:0]  base_x;
    logic [COORD_W-1:0]  base_y;
    logic [CSIZE_W-1:0]  cell_size;
    logic [SCORE_W-1:0]  visible_threshold;
    logic [SCORE_W-1:0]  occupied_threshold;
    logic [HEIGHT_W-1:0] height_threshold;
  } cfg_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  cells_in;
    logic [CNT_W-1:0]  visible;
    logic [CNT_W-1:0]  occupied;
    logic [PEAK_W-1:0] peak;
  } summary_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] num;
    logic [CNT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== hdl/sre_front.sv =====
// Front end: center test pipeline and per-slot accumulators.
// Pushes one summary per slot into the queue. Depends on sre_pkg.
module sre_front
  import sre_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SLOT_W-1:0]   in_slot_number,
  input  logic [COORD_W-1:0]  in_slot_min_x,
  input  logic [COORD_W-1:0]  in_slot_max_x,
  input  logic [COORD_W-1:0]  in_slot_min_y,
  input  logic [COORD_W-1:0]  in_slot_max_y,
  input  logic [IDX_W-1:0]    in_cell_x,
  input  logic [IDX_W-1:0]    in_cell_y,
  input  logic [SCORE_W-1:0]  in_cell_visibility,
  input  logic [SCORE_W-1:0]  in_cell_occupancy,
  input  logic [HEIGHT_W-1:0] in_cell_height,
  input  logic                in_last_cell,
  input  logic                q_full,
  output logic                q_push,
  output summary_t            q_data
);

  // stage 1: products and payload
  logic                v1_r;
  logic [PROD_W-1:0]   prod_x_r, prod_y_r;
  logic                on_grid_r;
  logic [COORD_W-1:0]  min_x_r, max_x_r, min_y_r, max_y_r;
  logic [SCORE_W-1:0]  vis1_r, occ1_r;
  logic [HEIGHT_W-1:0] h1_r;
  logic                last1_r;
  logic [SLOT_W-1:0]   slot1_r;

  // stage 2: classified cell
  logic                v2_r;
  logic                inside_r, vis_ok_r, occ_ok_r, h_pos_r;
  logic [PEAK_W-1:0]   h2_r;
  logic                last2_r;
  logic [SLOT_W-1:0]   slot2_r;

  // accumulators
  logic [CNT_W-1:0]  inside_cnt_r, visible_cnt_r, occupied_cnt_r;
  logic [PEAK_W-1:0] peak_r;
  logic [CNT_W-1:0]  inside_nxt, visible_nxt, occupied_nxt;
  logic [PEAK_W-1:0] peak_nxt;

  logic                        en;
  logic [PROD_W-1:0]           prod_x, prod_y;
  logic                        on_grid;
  logic signed [CENTER_W-1:0]  cx2, cy2, lo_x2, hi_x2, lo_y2, hi_y2;
  logic                        in_x, in_y;

  assign en       = !(v2_r && last2_r && q_full);
  assign in_stall = !en;

  always_comb begin
    prod_x  = PROD_W'({in_cell_x, 1'b1}) * PROD_W'(cfg.cell_size);
    prod_y  = PROD_W'({in_cell_y, 1'b1}) * PROD_W'(cfg.cell_size);
    on_grid = ({5'b0, in_cell_x} < 13'(GRID_WIDTH)) && ({5'b0, in_cell_y} < 13'(GRID_HEIGHT));
  end

  // doubled scale keeps the half-cell offset exact
  always_comb begin
    cx2   = $signed({{2{cfg.base_x[COORD_W-1]}}, cfg.base_x, 1'b0})
            + $signed({{(CENTER_W-PROD_W){1'b0}}, prod_x_r});
    cy2   = $signed({{2{cfg.base_y[COORD_W-1]}}, cfg.base_y, 1'b0})
            + $signed({{(CENTER_W-PROD_W){1'b0}}, prod_y_r});
    lo_x2 = $signed({{2{min_x_r[COORD_W-1]}}, min_x_r, 1'b0});
    hi_x2 = $signed({{2{max_x_r[COORD_W-1]}}, max_x_r, 1'b0});
    lo_y2 = $signed({{2{min_y_r[COORD_W-1]}}, min_y_r, 1'b0});
    hi_y2 = $signed({{2{max_y_r[COORD_W-1]}}, max_y_r, 1'b0});
    in_x  = (cx2 >= lo_x2) && (cx2 < hi_x2);
    in_y  = (cy2 >= lo_y2) && (cy2 < hi_y2);
  end

  always_comb begin
    inside_nxt   = inside_cnt_r;
    visible_nxt  = visible_cnt_r;
    occupied_nxt = occupied_cnt_r;
    peak_nxt     = peak_r;
    if (inside_r) begin
      if (inside_cnt_r != COUNT_MAX) inside_nxt = inside_cnt_r + 1'b1;
      if (vis_ok_r && visible_cnt_r != COUNT_MAX) visible_nxt = visible_cnt_r + 1'b1;
      if (occ_ok_r && occupied_cnt_r != COUNT_MAX) occupied_nxt = occupied_cnt_r + 1'b1;
      if (h_pos_r && h2_r > peak_r) peak_nxt = h2_r;
    end
  end

  assign q_push          = v2_r && last2_r && en;
  assign q_data.slot     = slot2_r;
  assign q_data.cells_in = inside_nxt;
  assign q_data.visible  = visible_nxt;
  assign q_data.occupied = occupied_nxt;
  assign q_data.peak     = peak_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x_r  <= prod_x;
      prod_y_r  <= prod_y;
      on_grid_r <= on_grid;
      min_x_r   <= in_slot_min_x;
      max_x_r   <= in_slot_max_x;
      min_y_r   <= in_slot_min_y;
      max_y_r   <= in_slot_max_y;
      vis1_r    <= in_cell_visibility;
      occ1_r    <= in_cell_occupancy;
      h1_r      <= in_cell_height;
      last1_r   <= in_last_cell;
      slot1_r   <= in_slot_number;

      inside_r  <= on_grid_r && in_x && in_y;
      vis_ok_r  <= vis1_r >= cfg.visible_threshold;
      occ_ok_r  <= (occ1_r >= cfg.occupied_threshold)
                   && ($signed(h1_r) >= $signed(cfg.height_threshold));
      h_pos_r   <= $signed(h1_r) > $signed(HEIGHT_W'(0));
      h2_r      <= h1_r[PEAK_W-1:0];
      last2_r   <= last1_r;
      slot2_r   <= slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_cnt_r   <= '0;
      visible_cnt_r  <= '0;
      occupied_cnt_r <= '0;
      peak_r         <= '0;
    end else if (v2_r && en) begin
      if (last2_r) begin
        inside_cnt_r   <= '0;
        visible_cnt_r  <= '0;
        occupied_cnt_r <= '0;
        peak_r         <= '0;
      end else begin
        inside_cnt_r   <= inside_nxt;
        visible_cnt_r  <= visible_nxt;
        occupied_cnt_r <= occupied_nxt;
        peak_r         <= peak_nxt;
      end
    end
  end

endmodule

// ===== hdl/sre_queue.sv =====
// Short summary queue between front end and back end.
// Depends on sre_pkg.
module sre_queue
  import sre_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  summary_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output summary_t head
);

  summary_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign full  = count_r == (Q_AW+1)'(Q_DEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hdl/sre_div.sv =====
// Restoring divider, one quotient bit per cycle: (num << 16) / den.
// Depends on sre_pkg.
module sre_div
  import sre_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0]     rem_r, den_r;
  logic [DIV_STEPS-1:0] dvd_r;
  logic [RATIO_W-1:0]   quo_r;
  logic [CNT_W:0]       rem_t, rem_sub;
  logic                 ge;

  always_comb begin
    rem_t   = {rem_r, dvd_r[DIV_STEPS-1]};
    rem_sub = rem_t - {1'b0, den_r};
    ge      = rem_t >= {1'b0, den_r};
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder stays below den, so one subtract per step is enough
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      den_r <= req.den;
      dvd_r <= {req.num, 16'b0};
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[CNT_W-1:0] : rem_t[CNT_W-1:0];
      dvd_r <= {dvd_r[DIV_STEPS-2:0], 1'b0};
      quo_r <= {quo_r[RATIO_W-2:0], ge};
    end
  end

endmodule

// ===== hdl/sre_back.sv =====
// Back end: pops slot summaries, forms ratios, confidence and category,
// and holds the result register. Depends on sre_pkg and sre_div.
module sre_back
  import sre_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                q_empty,
  input  summary_t            q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SLOT_W-1:0]   out_result_slot,
  output logic [RATIO_W-1:0]  out_occupied_ratio,
  output logic [RATIO_W-1:0]  out_visible_ratio,
  output logic [PEAK_W-1:0]   out_peak_height,
  output logic [RATIO_W-1:0]  out_confidence,
  output logic [1:0]          out_category
);

  back_state_t        state_r, state_nxt;
  summary_t           sum_r;
  logic [RATIO_W-1:0] occ_q_r, vis_q_r;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               load;

  logic               out_valid_r;
  logic [SLOT_W-1:0]  slot_o_r;
  logic [RATIO_W-1:0] occ_o_r, vis_o_r, conf_o_r;
  logic [PEAK_W-1:0]  peak_o_r;
  category_t          cat_o_r;

  logic [RATIO_W-1:0] other, best, conf;
  logic [RATIO_W:0]   conf_sum;
  category_t          cat;

  sre_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:    if (!q_empty) state_nxt = B_DIV_OCC;
      B_DIV_OCC: if (div_rsp.done) state_nxt = B_DIV_VIS;
      B_DIV_VIS: if (div_rsp.done) state_nxt = B_FIN;
      B_FIN:     if (load) state_nxt = B_IDLE;
      default:   state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = sum_r.visible;
    div_req.den   = sum_r.cells_in;
    load          = 1'b0;
    case (state_r)
      B_IDLE: begin
        q_pop         = !q_empty;
        div_req.start = !q_empty;
        div_req.num   = q_head.occupied;
        div_req.den   = q_head.cells_in;
      end
      B_DIV_OCC: div_req.start = div_rsp.done;
      B_FIN:     load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_comb begin
    other    = (occ_q_r <= ONE_Q16) ? ONE_Q16 - occ_q_r : '0;
    best     = (occ_q_r > other) ? occ_q_r : other;
    conf_sum = {1'b0, vis_q_r} + {1'b0, best};
    conf     = conf_sum[RATIO_W:1];
    if (conf > ONE_Q16) conf = ONE_Q16;
    if (vis_q_r < cfg.visible_threshold) cat = CAT_UNKNOWN;
    else if (occ_q_r >= cfg.occupied_threshold) cat = CAT_OCCUPIED;
    else cat = CAT_FREE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // empty slot: zero ratios regardless of the divider
  always_ff @(posedge clk) begin
    if (q_pop) sum_r <= q_head;
    if (state_r == B_DIV_OCC && div_rsp.done)
      occ_q_r <= (sum_r.cells_in == '0) ? '0 : div_rsp.quo;
    if (state_r == B_DIV_VIS && div_rsp.done)
      vis_q_r <= (sum_r.cells_in == '0) ? '0 : div_rsp.quo;
    if (load) begin
      slot_o_r <= sum_r.slot;
      occ_o_r  <= occ_q_r;
      vis_o_r  <= vis_q_r;
      peak_o_r <= sum_r.peak;
      conf_o_r <= conf;
      cat_o_r  <= cat;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_slot    = slot_o_r;
  assign out_occupied_ratio = occ_o_r;
  assign out_visible_ratio  = vis_o_r;
  assign out_peak_height    = peak_o_r;
  assign out_confidence     = conf_o_r;
  assign out_category       = cat_o_r;

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (occ_o_r <= ONE_Q16) && (vis_o_r <= ONE_Q16) && (conf_o_r <= ONE_Q16))
    else $error("result ratio above one");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == B_IDLE && !q_empty)
    else $error("summary popped outside idle");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == B_DIV_OCC || state_r == B_DIV_VIS))
    else $error("divider finished with no request pending");

  a_load_clears_fin: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r && state_r == B_IDLE)
    else $error("result not held after load");

endmodule

// ===== hdl/slot_region_evidence.sv =====
// Top level of the slot region evidence block: configuration registers,
// front end, summary queue and back end. Depends on sre_pkg and submodules.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall   one grid cell with its slot rectangle
//   out      output     out_valid/out_stall one result per slot, on its last cell
//   cfg      input      cfg_valid/cfg_ready register index and write data
//
// Cells are taken one per clock while in_stall is low; two pipeline stages
// (multiply, compare) precede the accumulators. Each slot then takes the back end
// two divider runs (occupied, then visible ratio) plus control states; the queue
// holds two finished slots. in_stall rises only while a last cell waits on a full
// queue. Synchronous active-low reset; no clearing pass. cfg_ready is always high.
module slot_region_evidence
  import sre_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SLOT_W-1:0]     in_slot_number,
  input  logic [COORD_W-1:0]    in_slot_min_x,
  input  logic [COORD_W-1:0]    in_slot_max_x,
  input  logic [COORD_W-1:0]    in_slot_min_y,
  input  logic [COORD_W-1:0]    in_slot_max_y,
  input  logic [IDX_W-1:0]      in_cell_x,
  input  logic [IDX_W-1:0]      in_cell_y,
  input  logic [SCORE_W-1:0]    in_cell_visibility,
  input  logic [SCORE_W-1:0]    in_cell_occupancy,
  input  logic [HEIGHT_W-1:0]   in_cell_height,
  input  logic                  in_last_cell,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SLOT_W-1:0]     out_result_slot,
  output logic [RATIO_W-1:0]    out_occupied_ratio,
  output logic [RATIO_W-1:0]    out_visible_ratio,
  output logic [PEAK_W-1:0]     out_peak_height,
  output logic [RATIO_W-1:0]    out_confidence,
  output logic [1:0]            out_category
);

  cfg_t     cfg_r;
  logic     q_push, q_full, q_pop, q_empty;
  summary_t q_data, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_x             <= '0;
      cfg_r.base_y             <= '0;
      cfg_r.cell_size          <= CSIZE_W'(6554);
      cfg_r.visible_threshold  <= SCORE_W'(32768);
      cfg_r.occupied_threshold <= SCORE_W'(32768);
      cfg_r.height_threshold   <= HEIGHT_W'(100);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:   cfg_r.base_x             <= cfg_data;
        REG_ORIGIN_Y:   cfg_r.base_y             <= cfg_data;
        REG_CELL_SIZE:  cfg_r.cell_size          <= cfg_data[CSIZE_W-1:0];
        REG_VIS_THR:    cfg_r.visible_threshold  <= cfg_data[SCORE_W-1:0];
        REG_OCC_THR:    cfg_r.occupied_threshold <= cfg_data[SCORE_W-1:0];
        REG_HEIGHT_THR: cfg_r.height_threshold   <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  sre_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_slot_number     (in_slot_number),
    .in_slot_min_x      (in_slot_min_x),
    .in_slot_max_x      (in_slot_max_x),
    .in_slot_min_y      (in_slot_min_y),
    .in_slot_max_y      (in_slot_max_y),
    .in_cell_x          (in_cell_x),
    .in_cell_y          (in_cell_y),
    .in_cell_visibility (in_cell_visibility),
    .in_cell_occupancy  (in_cell_occupancy),
    .in_cell_height     (in_cell_height),
    .in_last_cell       (in_last_cell),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_data             (q_data)
  );

  sre_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  sre_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_slot    (out_result_slot),
    .out_occupied_ratio (out_occupied_ratio),
    .out_visible_ratio  (out_visible_ratio),
    .out_peak_height    (out_peak_height),
    .out_confidence     (out_confidence),
    .out_category       (out_category)
  );

endmodule

// ===== bench/slot_region_evidence_test.sv =====
// Testbench for slot_region_evidence: drives grid cells and register writes,
// predicts per-slot evidence in a scoreboard class and checks every result.
// Depends on sre_pkg and the slot_region_evidence RTL.
module slot_region_evidence_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sre_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic [COORD_W-1:0]   COORD_LOWEST  = 32'h8000_0000;
  localparam logic [COORD_W-1:0]   COORD_HIGHEST = 32'h7FFF_FFFF;
  localparam longint UNIT_Q16      = ONE_Q16;
  localparam int INDEX_TOP         = (1 << IDX_W) - 1;
  localparam int CELLS_PER_PHASE   = 240;
  localparam int STEADY_CELLS      = 100;
  localparam int TAIL_CELLS        = 30;
  localparam int SETTLE_CYCLES     = 8;
  localparam int END_CYCLES        = 150;
  localparam int WATCH_LIMIT       = 5000;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [COORD_W-1:0]  min_x;
    logic [COORD_W-1:0]  max_x;
    logic [COORD_W-1:0]  min_y;
    logic [COORD_W-1:0]  max_y;
    logic [IDX_W-1:0]    cx;
    logic [IDX_W-1:0]    cy;
    logic [SCORE_W-1:0]  vis;
    logic [SCORE_W-1:0]  occ;
    logic [HEIGHT_W-1:0] hgt;
    logic                last;
  } grid_cell_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [RATIO_W-1:0] occ_ratio;
    logic [RATIO_W-1:0] vis_ratio;
    logic [PEAK_W-1:0]  peak;
    logic [RATIO_W-1:0] conf;
    category_t          cat;
  } evidence_t;

  class evidence_board;
    longint org_x;
    longint org_y;
    longint csize;
    logic [SCORE_W-1:0] vis_thr;
    logic [SCORE_W-1:0] occ_thr;
    logic signed [HEIGHT_W-1:0] hgt_thr;
    int n_inside;
    int n_visible;
    int n_occupied;
    int peak_mm;
    evidence_t pending[$];
    int mismatches;

    function new();
      org_x = 0;
      org_y = 0;
      csize = 6554;
      vis_thr = 17'd32768;
      occ_thr = 17'd32768;
      hgt_thr = 16'sd100;
      mismatches = 0;
      clear_slot();
    endfunction

    function void clear_slot();
      n_inside = 0;
      n_visible = 0;
      n_occupied = 0;
      peak_mm = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ORIGIN_X:   org_x = $signed(data);
        REG_ORIGIN_Y:   org_y = $signed(data);
        REG_CELL_SIZE:  csize = data[CSIZE_W-1:0];
        REG_VIS_THR:    vis_thr = data[SCORE_W-1:0];
        REG_OCC_THR:    occ_thr = data[SCORE_W-1:0];
        REG_HEIGHT_THR: hgt_thr = data[HEIGHT_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    endfunction

    function void note_cell(grid_cell_t gc);
      longint ctr_x2, ctr_y2, occ_r, vis_r, other, best, conf;
      logic signed [HEIGHT_W-1:0] h;
      evidence_t res;
      // centers at doubled scale keep the half cell exact
      ctr_x2 = 2 * org_x + longint'({gc.cx, 1'b1}) * csize;
      ctr_y2 = 2 * org_y + longint'({gc.cy, 1'b1}) * csize;
      h = gc.hgt;
      if (ctr_x2 >= 2 * longint'($signed(gc.min_x)) && ctr_x2 < 2 * longint'($signed(gc.max_x))
          && ctr_y2 >= 2 * longint'($signed(gc.min_y))
          && ctr_y2 < 2 * longint'($signed(gc.max_y))) begin
        if (n_inside < COUNT_MAX) n_inside++;
        if (h > 0 && int'(h) > peak_mm) peak_mm = h;
        if (gc.vis >= vis_thr && n_visible < COUNT_MAX) n_visible++;
        if (gc.occ >= occ_thr && h >= hgt_thr && n_occupied < COUNT_MAX) n_occupied++;
      end
      if (!gc.last) return;
      occ_r = (n_inside == 0) ? 0 : longint'(n_occupied) * UNIT_Q16 / longint'(n_inside);
      vis_r = (n_inside == 0) ? 0 : longint'(n_visible) * UNIT_Q16 / longint'(n_inside);
      other = (occ_r <= UNIT_Q16) ? UNIT_Q16 - occ_r : 0;
      best = (occ_r > other) ? occ_r : other;
      conf = (vis_r + best) / 2;
      if (conf > UNIT_Q16) conf = UNIT_Q16;
      res.slot = gc.slot;
      res.occ_ratio = occ_r[RATIO_W-1:0];
      res.vis_ratio = vis_r[RATIO_W-1:0];
      res.peak = peak_mm[PEAK_W-1:0];
      res.conf = conf[RATIO_W-1:0];
      if (vis_r < longint'(vis_thr)) res.cat = CAT_UNKNOWN;
      else if (occ_r >= longint'(occ_thr)) res.cat = CAT_OCCUPIED;
      else res.cat = CAT_FREE;
      pending = {pending, res};
      clear_slot();
    endfunction

    function void check_result(evidence_t got);
      evidence_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result for slot %0d arrived with none pending", $time, got.slot);
        return;
      end
      want = pending.pop_front();
      if (got.slot != want.slot || got.occ_ratio != want.occ_ratio
          || got.vis_ratio != want.vis_ratio || got.peak != want.peak
          || got.conf != want.conf || got.cat != want.cat) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("[%0t] evidence mismatch (expected/actual): slot %0d/%0d occ %0d/%0d ",
                 $time, want.slot, got.slot, want.occ_ratio, got.occ_ratio);
          $display("vis %0d/%0d peak %0d/%0d conf %0d/%0d cat %0d/%0d",
                   want.vis_ratio, got.vis_ratio, want.peak, got.peak,
                   want.conf, got.conf, want.cat, got.cat);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  grid_cell_t            in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SLOT_W-1:0]     out_result_slot;
  logic [RATIO_W-1:0]    out_occupied_ratio;
  logic [RATIO_W-1:0]    out_visible_ratio;
  logic [PEAK_W-1:0]     out_peak_height;
  logic [RATIO_W-1:0]    out_confidence;
  logic [1:0]            out_category;

  evidence_board board;
  evidence_t     seen;
  bit            steady = 1'b0;
  int            sent = 0;
  int            quiet = 0;

  slot_region_evidence dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_slot_number     (in_item.slot),
    .in_slot_min_x      (in_item.min_x),
    .in_slot_max_x      (in_item.max_x),
    .in_slot_min_y      (in_item.min_y),
    .in_slot_max_y      (in_item.max_y),
    .in_cell_x          (in_item.cx),
    .in_cell_y          (in_item.cy),
    .in_cell_visibility (in_item.vis),
    .in_cell_occupancy  (in_item.occ),
    .in_cell_height     (in_item.hgt),
    .in_last_cell       (in_item.last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_slot    (out_result_slot),
    .out_occupied_ratio (out_occupied_ratio),
    .out_visible_ratio  (out_visible_ratio),
    .out_peak_height    (out_peak_height),
    .out_confidence     (out_confidence),
    .out_category       (out_category)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 24);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.slot = out_result_slot;
      seen.occ_ratio = out_occupied_ratio;
      seen.vis_ratio = out_visible_ratio;
      seen.peak = out_peak_height;
      seen.conf = out_confidence;
      seen.cat = category_t'(out_category);
      board.check_result(seen);
    end
  end

  // any accepted transaction on any channel resets the stall counter
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == WATCH_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic grid_cell_t grid_cell(logic [SLOT_W-1:0] slot,
      logic [COORD_W-1:0] min_x, logic [COORD_W-1:0] max_x,
      logic [COORD_W-1:0] min_y, logic [COORD_W-1:0] max_y,
      logic [IDX_W-1:0] cx, logic [IDX_W-1:0] cy,
      logic [SCORE_W-1:0] vis, logic [SCORE_W-1:0] occ,
      logic [HEIGHT_W-1:0] hgt, logic last);
    grid_cell_t gc;
    gc.slot = slot;
    gc.min_x = min_x;
    gc.max_x = max_x;
    gc.min_y = min_y;
    gc.max_y = max_y;
    gc.cx = cx;
    gc.cy = cy;
    gc.vis = vis;
    gc.occ = occ;
    gc.hgt = hgt;
    gc.last = last;
    return gc;
  endfunction

  // bound placed on a cell edge, on a center or one off it, or anywhere
  function automatic logic [COORD_W-1:0] bound_near(int idx, bit on_y);
    longint org, ctr2;
    org = on_y ? board.org_y : board.org_x;
    ctr2 = 2 * org + longint'(2 * idx + 1) * board.csize;
    case ($urandom_range(0, 9))
      0, 1, 2: return COORD_W'(org + longint'(idx) * board.csize);
      3, 4:    return COORD_W'(ctr2 >>> 1);
      5, 6:    return COORD_W'((ctr2 >>> 1) + 1);
      7, 8:    return COORD_W'((ctr2 >>> 1) - 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] near_index(int lo, int span);
    int p;
    p = lo + int'($urandom_range(0, span + 2)) - 1;
    if (p < 0) p = 0;
    if (p > INDEX_TOP) p = INDEX_TOP;
    return p[IDX_W-1:0];
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score(int thr);
    int v;
    int extremes[3] = '{0, 65536, 131071};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = thr + int'($urandom_range(0, 4)) - 2;
      4, 5, 6, 7: v = $urandom_range(0, 65536);
      8:          v = $urandom_range(0, 131071);
      default:    v = extremes[$urandom_range(0, 2)];
    endcase
    if (v < 0) v = 0;
    if (v > 131071) v = 131071;
    return v[SCORE_W-1:0];
  endfunction

  function automatic logic [HEIGHT_W-1:0] pick_height(int thr);
    int v;
    int extremes[3] = '{-32768, 0, 32767};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = thr + int'($urandom_range(0, 4)) - 2;
      4, 5, 6:    v = $urandom_range(0, 32767);
      7, 8:       v = int'($urandom_range(0, 65535)) - 32768;
      default:    v = extremes[$urandom_range(0, 2)];
    endcase
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[HEIGHT_W-1:0];
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every pending slot result is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy,
      logic [CSIZE_W-1:0] cs, logic [SCORE_W-1:0] vt, logic [SCORE_W-1:0] ot,
      logic [HEIGHT_W-1:0] ht);
    logic [CFG_DATA_W-1:0] word;
    wait_drain();
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Y, oy);
    // junk in the unused upper bits must be ignored
    word = $urandom();
    word[CSIZE_W-1:0] = cs;
    cfg_write(REG_CELL_SIZE, word);
    word = $urandom();
    word[SCORE_W-1:0] = vt;
    cfg_write(REG_VIS_THR, word);
    word = $urandom();
    word[SCORE_W-1:0] = ot;
    cfg_write(REG_OCC_THR, word);
    word = $urandom();
    word[HEIGHT_W-1:0] = ht;
    cfg_write(REG_HEIGHT_THR, word);
    cfg_write(REG_SPARE_A, $urandom());
    cfg_write(REG_SPARE_B, $urandom());
  endtask

  task automatic send_cell(grid_cell_t gc);
    while (!steady && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item <= gc;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_cell(gc);
    sent++;
  endtask

  // one slot: a rectangle around a small block of cells, cells mostly near it
  task automatic run_slot(int n_cells);
    grid_cell_t gc;
    int lo_x, lo_y, span_x, span_y;
    lo_x = $urandom_range(0, INDEX_TOP);
    lo_y = $urandom_range(0, INDEX_TOP);
    span_x = $urandom_range(0, 6);
    span_y = $urandom_range(0, 6);
    gc.slot = SLOT_W'($urandom());
    gc.min_x = bound_near(lo_x, 1'b0);
    gc.max_x = bound_near(lo_x + span_x + 1, 1'b0);
    gc.min_y = bound_near(lo_y, 1'b1);
    gc.max_y = bound_near(lo_y + span_y + 1, 1'b1);
    for (int k = 0; k < n_cells; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        gc.cx = IDX_W'($urandom());
        gc.cy = IDX_W'($urandom());
      end else begin
        gc.cx = near_index(lo_x, span_x);
        gc.cy = near_index(lo_y, span_y);
      end
      gc.vis = pick_score(int'(board.vis_thr));
      gc.occ = pick_score(int'(board.occ_thr));
      gc.hgt = pick_height(int'(board.hgt_thr));
      gc.last = (k == n_cells - 1);
      send_cell(gc);
    end
  endtask

  task automatic run_random(int n_items);
    int goal;
    goal = sent + n_items;
    while (sent < goal) begin
      run_slot(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8));
      if ($urandom_range(0, 59) == 0) wait_drain();
    end
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: centers of cell i sit at (2i+1) * 3277
    // empty slot, rectangle inverted
    send_cell(grid_cell(16'h0000, COORD_HIGHEST, COORD_LOWEST, COORD_HIGHEST, COORD_LOWEST,
                        8'd0, 8'd0, ONE_Q16, ONE_Q16, 16'd500, 1'b1));
    // lower bound hits a center (in), upper bound hits a center (out)
    send_cell(grid_cell(16'hFFFF, 32'd3277, 32'd9831, 32'd3277, 32'd9831,
                        8'd0, 8'd0, 17'h1FFFF, 17'h1FFFF, 16'h7FFF, 1'b0));
    send_cell(grid_cell(16'hFFFF, 32'd3277, 32'd9831, 32'd3277, 32'd9831,
                        8'd1, 8'd1, 17'd0, 17'd0, 16'hFFFF, 1'b1));
    // thresholds met exactly and missed by one, corner indices
    send_cell(grid_cell(16'h5A5A, COORD_LOWEST, COORD_HIGHEST, COORD_LOWEST, COORD_HIGHEST,
                        8'd255, 8'd255, 17'd32768, 17'd32768, 16'd100, 1'b0));
    send_cell(grid_cell(16'h5A5A, COORD_LOWEST, COORD_HIGHEST, COORD_LOWEST, COORD_HIGHEST,
                        8'd255, 8'd0, 17'd32767, 17'd32768, 16'd99, 1'b0));
    send_cell(grid_cell(16'h5A5A, COORD_LOWEST, COORD_HIGHEST, COORD_LOWEST, COORD_HIGHEST,
                        8'd0, 8'd255, ONE_Q16, 17'd32767, 16'h7FFF, 1'b0));
    send_cell(grid_cell(16'h5A5A, COORD_LOWEST, COORD_HIGHEST, COORD_LOWEST, COORD_HIGHEST,
                        8'd128, 8'd127, 17'd0, ONE_Q16, 16'h8000, 1'b0));
    send_cell(grid_cell(16'h5A5A, COORD_LOWEST, COORD_HIGHEST, COORD_LOWEST, COORD_HIGHEST,
                        8'd170, 8'd85, 17'h1FFFF, 17'd0, 16'd0, 1'b1));
    // free: all visible, none occupied
    for (int k = 0; k < 3; k++)
      send_cell(grid_cell(16'h00FF, COORD_LOWEST, COORD_HIGHEST, COORD_LOWEST, COORD_HIGHEST,
                          8'(k), 8'(k), ONE_Q16, 17'd0, 16'd50, k == 2));
    // one occupied cell in three
    for (int k = 0; k < 3; k++)
      send_cell(grid_cell(16'hFF00, COORD_LOWEST, COORD_HIGHEST, COORD_LOWEST, COORD_HIGHEST,
                          8'(k + 10), 8'd3, ONE_Q16, (k == 1) ? ONE_Q16 : 17'd0, 16'd200,
                          k == 2));
    // negative heights only: peak stays zero
    send_cell(grid_cell(16'h1234, COORD_LOWEST, COORD_HIGHEST, COORD_LOWEST, COORD_HIGHEST,
                        8'd7, 8'd9, 17'd32768, ONE_Q16, 16'hFFFB, 1'b0));
    send_cell(grid_cell(16'h1234, COORD_LOWEST, COORD_HIGHEST, COORD_LOWEST, COORD_HIGHEST,
                        8'd9, 8'd7, 17'd32768, ONE_Q16, 16'h8000, 1'b1));

    set_config(32'd0, 32'd0, 21'd6554, 17'd32768, 17'd32768, 16'd100);
    run_random(CELLS_PER_PHASE);
    set_config(COORD_LOWEST, COORD_LOWEST, 21'h1FFFFF, 17'd0, 17'h1FFFF, 16'h8000);
    run_random(CELLS_PER_PHASE);
    // zero cell size: every center is the origin
    set_config(32'h7FFF_FFFE, 32'h0001_0000, 21'd0, ONE_Q16, 17'd0, 16'h7FFF);
    run_random(CELLS_PER_PHASE);
    set_config(32'hFFFF_0000, 32'h7FFF_FE00, 21'd1, 17'h1FFFF, ONE_Q16, 16'd0);
    run_random(CELLS_PER_PHASE);
    set_config($urandom(), $urandom(), CSIZE_W'($urandom_range(1, 1048576)),
               SCORE_W'($urandom_range(0, 65536)), SCORE_W'($urandom_range(0, 65536)),
               HEIGHT_W'($urandom()));
    run_random(CELLS_PER_PHASE);

    // no idling on either side for a stretch
    set_config(32'd0, 32'd0, 21'd1, 17'd32768, 17'd32768, 16'd0);
    steady = 1'b1;
    run_random(STEADY_CELLS);
    steady = 1'b0;
    run_random(TAIL_CELLS);

    wait_drain();
    repeat (END_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
